// ===== rtl/quadratic_roots_vertex_points_unit_defines.svh =====
// assertion helpers used by the rtl in qrv_back
`ifndef QUADRATIC_ROOTS_VERTEX_POINTS_UNIT_DEFINES_SVH
`define QUADRATIC_ROOTS_VERTEX_POINTS_UNIT_DEFINES_SVH

// same-cycle implication
`define QRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qrv_pkg.sv =====
`timescale 1ns / 1ps
package qrv_pkg;

    localparam int COEF_FRAC_BITS = 8;
    localparam int OUT_FRAC_BITS  = 16;
    localparam int COEF_W         = 16;
    localparam int PT_W           = 40;
    localparam int HALF_W         = PT_W / 2;
    localparam int D_W            = 34;
    localparam int NUM_W          = 36;
    localparam int DEN_W          = 17;
    localparam int ROOT_W         = D_W / 2;
    localparam int AX_W           = COEF_W + PT_W;
    localparam int SUM_W          = AX_W + 1;
    localparam int WMAG_W         = SUM_W - COEF_FRAC_BITS;
    localparam int PROD_W         = WMAG_W + PT_W;
    localparam int IN_DATA_W      = 3 * COEF_W;
    localparam int OUT_DATA_W     = 2 * PT_W;
    localparam int OUT_USER_W     = 4;
    localparam int FIFO_DEPTH     = 4;

    localparam logic signed [PT_W-1:0] SAT_MAX = {1'b0, {(PT_W-1){1'b1}}};
    localparam logic signed [PT_W-1:0] SAT_MIN = {1'b1, {(PT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_ROOT1  = 2'd1,
        KIND_ROOT2  = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DISC_NEG  = 2'd0,
        DISC_ZERO = 2'd1,
        DISC_POS  = 2'd2
    } t_disc;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [D_W-1:0]    d;
        t_disc                    disc;
        logic                     err;
    } t_item;

    typedef enum logic [3:0] {
        S_POP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_EV0,
        S_EV1,
        S_EV2,
        S_EV3,
        S_EV4,
        S_EV5,
        S_EMIT
    } t_state;

    function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [PT_W:0] v);
        logic signed [PT_W-1:0] r;
        if (v[PT_W] != v[PT_W-1]) begin
            r = v[PT_W] ? SAT_MIN : SAT_MAX;
        end else begin
            r = v[PT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/quadratic_roots_vertex_points_unit.sv =====
`timescale 1ns / 1ps
// Takes signed Q8.8 coefficients a, b, c and returns seven Q24.16 points per transaction:
// vertex, first root, second root, then samples at vertex x -2, -1, +1, +2 (tlast on the
// last); a zero a gives a single error transaction instead. The front computes the
// discriminant and classifies the item in the accepting cycle and parks it in a small
// queue, so new input is taken while earlier items are still being worked on. The back
// sequencer handles one item at a time: a bit-serial divider, a bit-serial square root and a
// six-step multiply chain for each f(x).
module quadratic_roots_vertex_points_unit #(
    parameter int FIFO_DEPTH = qrv_pkg::FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // coeff_a, coeff_b, coeff_c
    input  logic [qrv_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // point_x, point_y
    output logic [qrv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // point_kind, point_valid, coeff_error
    output logic [qrv_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);
    import qrv_pkg::*;

    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;

    qrv_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    qrv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    qrv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_item   (w_pop_item),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/qrv_front.sv =====
`timescale 1ns / 1ps
module qrv_front (
    input  logic                           i_valid,
    input  logic [qrv_pkg::IN_DATA_W-1:0]  i_data,
    input  logic                           i_full,
    output logic                           o_ready,
    output logic                           o_push,
    output qrv_pkg::t_item                 o_item
);
    import qrv_pkg::*;

    logic signed [COEF_W-1:0]   w_a;
    logic signed [COEF_W-1:0]   w_b;
    logic signed [COEF_W-1:0]   w_c;
    logic signed [2*COEF_W-1:0] w_bb;
    logic signed [2*COEF_W-1:0] w_ac;
    logic signed [D_W-1:0]      w_d;

    assign w_a  = i_data[COEF_W-1:0];
    assign w_b  = i_data[2*COEF_W-1:COEF_W];
    assign w_c  = i_data[3*COEF_W-1:2*COEF_W];
    assign w_bb = w_b * w_b;
    assign w_ac = w_a * w_c;
    assign w_d  = {{(D_W-2*COEF_W){w_bb[2*COEF_W-1]}}, w_bb} - {w_ac, 2'b00};

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.a   = w_a;
        o_item.b   = w_b;
        o_item.c   = w_c;
        o_item.d   = w_d;
        o_item.err = (w_a == '0);
        if (w_d[D_W-1]) begin
            o_item.disc = DISC_NEG;
        end else if (w_d == '0) begin
            o_item.disc = DISC_ZERO;
        end else begin
            o_item.disc = DISC_POS;
        end
    end

endmodule

// ===== rtl/qrv_fifo.sv =====
`timescale 1ns / 1ps
module qrv_fifo #(
    parameter int DEPTH = qrv_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qrv_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output qrv_pkg::t_item o_item
);
    import qrv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/qrv_div.sv =====
`timescale 1ns / 1ps
module qrv_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [qrv_pkg::NUM_W-1:0]    i_num,
    input  logic signed [qrv_pkg::DEN_W-1:0]    i_den,
    output logic                                o_done,
    output logic signed [qrv_pkg::NUM_W-1:0]    o_quo
);
    import qrv_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [DEN_W-1:0]  r_dmag;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dmag});
    assign o_done  = r_done;
    assign o_quo   = r_neg ? -r_quo : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_dmag <= i_den[DEN_W-1] ? -i_den : i_den;
            r_quo  <= i_num[NUM_W-1] ? -i_num : i_num;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? DEN_W'(w_trial - {1'b0, r_dmag}) : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/qrv_sqrt.sv =====
`timescale 1ns / 1ps
module qrv_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [qrv_pkg::D_W-1:0]       i_rad,
    output logic                          o_done,
    output logic [qrv_pkg::ROOT_W-1:0]    o_root
);
    import qrv_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [D_W-1:0]    r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  w_trem;
    logic [REM_W+1:0]  w_ttst;
    logic              w_fit;

    assign w_trem = {r_rem, r_rad[D_W-1:D_W-2]};
    assign w_ttst = {{(REM_W-ROOT_W){1'b0}}, r_root, 2'b01};
    assign w_fit  = (w_trem >= w_ttst);
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[D_W-3:0], 2'b00};
            r_rem  <= w_fit ? REM_W'(w_trem - w_ttst) : REM_W'(w_trem);
            r_root <= {r_root[ROOT_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/qrv_back.sv =====
`timescale 1ns / 1ps
`include "quadratic_roots_vertex_points_unit_defines.svh"
module qrv_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  qrv_pkg::t_item                    i_item,
    output logic                              o_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [qrv_pkg::OUT_DATA_W-1:0]    o_tdata,
    output logic [qrv_pkg::OUT_USER_W-1:0]    o_tuser,
    output logic                              o_tlast
);
    import qrv_pkg::*;

    localparam int O = OUT_FRAC_BITS;
    localparam int F = COEF_FRAC_BITS;
    localparam logic signed [PT_W:0] ONE_O = (PT_W+1)'(1) <<< O;

    t_state                    r_state;
    t_state                    n_state;
    logic [2:0]                r_phase;
    t_item                     r_item;
    logic signed [PT_W-1:0]    r_x0;
    logic signed [PT_W-1:0]    r_x;
    logic [ROOT_W-1:0]         r_s;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [AX_W-1:0]    r_ax;
    logic [PT_W-1:0]           r_xmag;
    logic [WMAG_W-1:0]         r_wmag;
    logic                      r_neg;
    logic [WMAG_W+HALF_W-1:0]  r_plo;
    logic [WMAG_W+HALF_W-1:0]  r_phi;
    logic signed [PT_W-1:0]    r_p;
    logic signed [PT_W-1:0]    r_pt_x;
    logic signed [PT_W-1:0]    r_pt_y;
    logic                      r_pt_valid;
    logic                      r_ovalid;
    logic [OUT_DATA_W-1:0]     r_odata;
    logic [OUT_USER_W-1:0]     r_ouser;
    logic                      r_olast;

    logic signed [COEF_W-1:0]  w_a;
    logic signed [COEF_W-1:0]  w_b;
    logic signed [COEF_W-1:0]  w_c;
    logic signed [COEF_W:0]    w_negb;
    logic signed [COEF_W-1:0]  w_pop_b;
    logic signed [COEF_W:0]    w_pop_negb;
    logic signed [COEF_W+1:0]  w_rnum1;
    logic signed [COEF_W+1:0]  w_rnum2;
    logic signed [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]          w_sum_mag;
    logic [PROD_W-1:0]         w_prod;
    logic [PROD_W-O-1:0]       w_sh;
    logic                      w_big;
    logic signed [PT_W-1:0]    w_p;
    logic signed [PT_W:0]      w_ysum;
    logic signed [PT_W:0]      w_off;
    logic                      w_load;
    logic                      w_div_start;
    logic                      w_div_done;
    logic signed [NUM_W-1:0]   w_quo;
    logic                      w_sq_start;
    logic                      w_sq_done;
    logic [ROOT_W-1:0]         w_root;
    t_kind                     w_kind;
    logic                      w_last;

    qrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   ({r_item.a, 1'b0}),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    qrv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (r_item.d),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_a        = r_item.a;
    assign w_b        = r_item.b;
    assign w_c        = r_item.c;
    assign w_negb     = -{w_b[COEF_W-1], w_b};
    assign w_pop_b    = i_item.b;
    assign w_pop_negb = -{w_pop_b[COEF_W-1], w_pop_b};
    assign w_rnum1    = {w_negb[COEF_W], w_negb} - {1'b0, w_root};
    assign w_rnum2    = {w_negb[COEF_W], w_negb} + {1'b0, r_s};

    // polynomial evaluation datapath
    assign w_sum     = (SUM_W)'(r_ax)
                     + {{(SUM_W-COEF_W-O){w_b[COEF_W-1]}}, w_b, {O{1'b0}}};
    assign w_sum_mag = w_sum[SUM_W-1] ? -w_sum : w_sum;
    assign w_prod    = {{HALF_W{1'b0}}, r_plo} + {r_phi, {HALF_W{1'b0}}};
    assign w_sh      = w_prod[PROD_W-1:O];
    assign w_big     = (w_sh[PROD_W-O-1:PT_W-1] != '0);
    assign w_ysum    = (PT_W+1)'(r_p)
                     + {{(PT_W+1-COEF_W-(O-F)){w_c[COEF_W-1]}}, w_c, {(O-F){1'b0}}};

    always_comb begin
        if (r_neg) begin
            w_p = w_big ? SAT_MIN : -{1'b0, w_sh[PT_W-2:0]};
        end else begin
            w_p = w_big ? SAT_MAX : {1'b0, w_sh[PT_W-2:0]};
        end
    end

    // sample offsets for the phase about to start
    always_comb begin
        case (r_phase)
            3'd2:    w_off = -(ONE_O <<< 1);
            3'd3:    w_off = -ONE_O;
            3'd4:    w_off = ONE_O;
            default: w_off = ONE_O <<< 1;
        endcase
    end

    always_comb begin
        case (r_phase)
            3'd0:    w_kind = KIND_VERTEX;
            3'd1:    w_kind = KIND_ROOT1;
            3'd2:    w_kind = KIND_ROOT2;
            default: w_kind = KIND_SAMPLE;
        endcase
    end

    assign w_last = r_item.err || (r_phase == 3'd6);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_POP: begin
                if (!i_empty) begin
                    n_state = i_item.err ? S_EMIT : S_DIV_GO;
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_phase == 3'd0) ? S_EV0 : S_EMIT;
                end
            end
            S_SQ_GO:    n_state = S_SQ_WAIT;
            S_SQ_WAIT: begin
                if (w_sq_done) begin
                    n_state = S_DIV_GO;
                end
            end
            S_EV0:      n_state = S_EV1;
            S_EV1:      n_state = S_EV2;
            S_EV2:      n_state = S_EV3;
            S_EV3:      n_state = S_EV4;
            S_EV4:      n_state = S_EV5;
            S_EV5:      n_state = S_EMIT;
            S_EMIT: begin
                if (w_load) begin
                    if (w_last) begin
                        n_state = S_POP;
                    end else if (r_phase == 3'd0) begin
                        n_state = (r_item.disc == DISC_POS) ? S_SQ_GO : S_EMIT;
                    end else if (r_phase == 3'd1) begin
                        n_state = (r_item.disc == DISC_POS) ? S_DIV_GO : S_EMIT;
                    end else begin
                        n_state = S_EV0;
                    end
                end
            end
            default:    n_state = S_POP;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        w_sq_start  = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            S_POP:    o_pop       = !i_empty;
            S_DIV_GO: w_div_start = 1'b1;
            S_SQ_GO:  w_sq_start  = 1'b1;
            S_EMIT:   w_load      = !r_ovalid || i_tready;
            default:  o_pop       = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_POP: begin
                r_item     <= i_item;
                r_pt_x     <= '0;
                r_pt_y     <= '0;
                r_pt_valid <= 1'b0;
                r_num      <= {{(NUM_W-COEF_W-1-O){w_pop_negb[COEF_W]}}, w_pop_negb,
                               {O{1'b0}}};
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    if (r_phase == 3'd0) begin
                        r_x0 <= {{(PT_W-NUM_W){w_quo[NUM_W-1]}}, w_quo};
                        r_x  <= {{(PT_W-NUM_W){w_quo[NUM_W-1]}}, w_quo};
                    end else begin
                        r_pt_x     <= {{(PT_W-NUM_W){w_quo[NUM_W-1]}}, w_quo};
                        r_pt_y     <= '0;
                        r_pt_valid <= 1'b1;
                    end
                end
            end
            S_SQ_WAIT: begin
                if (w_sq_done) begin
                    r_s   <= w_root;
                    r_num <= {{(NUM_W-COEF_W-2-O){w_rnum1[COEF_W+1]}}, w_rnum1, {O{1'b0}}};
                end
            end
            S_EV0: begin
                r_ax   <= w_a * r_x;
                r_xmag <= r_x[PT_W-1] ? -r_x : r_x;
            end
            S_EV1: begin
                r_wmag <= w_sum_mag[SUM_W-1:F];
                r_neg  <= w_sum[SUM_W-1] ^ r_x[PT_W-1];
            end
            S_EV2: r_plo <= r_wmag * r_xmag[HALF_W-1:0];
            S_EV3: r_phi <= r_wmag * r_xmag[PT_W-1:HALF_W];
            S_EV4: r_p   <= w_p;
            S_EV5: begin
                r_pt_x     <= r_x;
                r_pt_y     <= sat_pt(w_ysum);
                r_pt_valid <= 1'b1;
            end
            S_EMIT: begin
                if (w_load && !w_last) begin
                    if (r_phase == 3'd0) begin
                        r_pt_x     <= (r_item.disc == DISC_ZERO) ? r_x0 : '0;
                        r_pt_y     <= '0;
                        r_pt_valid <= (r_item.disc == DISC_ZERO);
                    end else if (r_phase == 3'd1) begin
                        r_pt_x     <= '0;
                        r_pt_y     <= '0;
                        r_pt_valid <= 1'b0;
                        r_num      <= {{(NUM_W-COEF_W-2-O){w_rnum2[COEF_W+1]}}, w_rnum2,
                                       {O{1'b0}}};
                    end else begin
                        r_x <= sat_pt((PT_W+1)'(r_x0) + w_off);
                    end
                end
            end
            default: r_p <= r_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= {r_pt_y, r_pt_x};
            r_ouser <= {r_item.err, r_pt_valid, w_kind};
            r_olast <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_POP;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_phase <= '0;
            end else if (w_load && !w_last && r_state == S_EMIT) begin
                r_phase <= r_phase + 1'b1;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_ouser;
    assign o_tlast  = r_olast;

    `QRV_ASSERT_IMP(a_err_last, i_clk, i_rst_n, o_tvalid && o_tuser[3],
        o_tlast && !o_tuser[2], "error transaction must be last and carry no point")
    `QRV_ASSERT_IMP(a_div_done, i_clk, i_rst_n, w_div_done, r_state == S_DIV_WAIT,
        "divider finished outside its wait state")
    `QRV_ASSERT_IMP(a_sq_done, i_clk, i_rst_n, w_sq_done, r_state == S_SQ_WAIT,
        "square root finished outside its wait state")
    `QRV_ASSERT_NXT(a_pop_leaves, i_clk, i_rst_n, o_pop, r_state != S_POP,
        "item taken from the queue but sequencer stayed idle")

endmodule
